/* rtl/core/gtg_pkg.sv */
package gtg_pkg;

    // Default build parameters
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DATA_WIDTH_DEF    = 16;

    // Extra bits on the CORDIC x/y words beyond DATA_WIDTH (Q7 integer part plus growth)
    localparam int XY_GUARD  = 10;
    // Angle word inside the CORDIC: Q.32 radians with room for pre-rotation and growth
    localparam int ANGLE_W   = 38;
    localparam int ATAN_ENTRIES = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [ANGLE_W-1:0] PI_Q32      = 38'sd13493037705;
    localparam logic signed [ANGLE_W-1:0] HALF_PI_Q32 = 38'sd6746518852;
    localparam int PI_Q13 = 25736;

    // atan(2^-i) in Q.32, rounded
    localparam logic [31:0] ATAN_Q32 [ATAN_ENTRIES] = '{
        32'd3373259426, 32'd1991351317, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512
    };

    // Register reset values
    localparam logic [14:0] MAX_SPEED_RST   = 15'd2048;
    localparam logic [14:0] STOP_RADIUS_RST = 15'd102;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GOAL_X      = 4'd0,
        REG_GOAL_Y      = 4'd1,
        REG_MAX_SPEED   = 4'd2,
        REG_STOP_RADIUS = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic [14:0]        max_speed;
        logic [14:0]        stop_radius;
    } ctrl_cfg_t;

    typedef enum logic {
        CELL_ROTATE,
        CELL_VECTOR
    } cell_mode_t;

    // Clamp the stage count to the arctangent table
    function automatic int stage_count(input int stages);
        return (stages > ATAN_ENTRIES) ? ATAN_ENTRIES : stages;
    endfunction

    // Squared CORDIC gain in Q2.30, truncating at each stage
    function automatic longint unsigned gain_sq(input int stages);
        longint unsigned k;
        k = 64'd1 << 30;
        for (int i = 0; i < ATAN_ENTRIES; i++) begin
            if (i < stages) begin
                k = k + (k >> (2 * i));
            end
        end
        return k;
    endfunction

endpackage

/* rtl/core/gtg_front.sv */
module gtg_front
    import gtg_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  ctrl_cfg_t                       cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [15:0]              pose_x,
    input  logic signed [15:0]              pose_y,
    input  logic signed [15:0]              pose_heading,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [DATA_WIDTH+XY_GUARD-1:0] out_x,
    output logic signed [DATA_WIDTH+XY_GUARD-1:0] out_y,
    output logic signed [ANGLE_W-1:0]       out_z
);

    localparam int W     = DATA_WIDTH + XY_GUARD;
    localparam int SHIFT = DATA_WIDTH - 10;

    logic signed [16:0]        err_x;
    logic signed [16:0]        err_y;
    logic signed [16:0]        head_neg;
    logic signed [W-1:0]       x_wide;
    logic signed [W-1:0]       y_wide;
    logic signed [ANGLE_W-1:0] z_wide;
    logic signed [W-1:0]       x_next;
    logic signed [W-1:0]       y_next;
    logic signed [ANGLE_W-1:0] z_next;
    logic                      valid_reg;
    logic signed [W-1:0]       x_reg;
    logic signed [W-1:0]       y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    logic                      load;

    // World-frame error, widened to the CORDIC word, and rotation angle = -heading
    always_comb
    begin
        err_x    = {cfg.goal_x[15], cfg.goal_x} - {pose_x[15], pose_x};
        err_y    = {cfg.goal_y[15], cfg.goal_y} - {pose_y[15], pose_y};
        head_neg = 17'sd0 - {pose_heading[15], pose_heading};
        x_wide   = {{(W-17){err_x[16]}}, err_x} <<< SHIFT;
        y_wide   = {{(W-17){err_y[16]}}, err_y} <<< SHIFT;
        z_wide   = {{(ANGLE_W-17){head_neg[16]}}, head_neg} <<< 19;

        // Fold angles beyond +-pi/2 by negating the vector
        x_next = x_wide;
        y_next = y_wide;
        z_next = z_wide;
        if (z_wide > HALF_PI_Q32)
        begin
            x_next = -x_wide;
            y_next = -y_wide;
            z_next = z_wide - PI_Q32;
        end
        else if (z_wide < -HALF_PI_Q32)
        begin
            x_next = -x_wide;
            y_next = -y_wide;
            z_next = z_wide + PI_Q32;
        end
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Hold the word until the next cell takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

/* rtl/core/gtg_cordic_cell.sv */
module gtg_cordic_cell
    import gtg_pkg::*;
#(
    parameter int         W     = DATA_WIDTH_DEF + XY_GUARD,
    parameter int         STAGE = 0,
    parameter cell_mode_t MODE  = CELL_ROTATE,
    parameter bit         PRE   = 1'b0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [W-1:0]       in_x,
    input  logic signed [W-1:0]       in_y,
    input  logic signed [ANGLE_W-1:0] in_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [W-1:0]       out_x,
    output logic signed [W-1:0]       out_y,
    output logic signed [ANGLE_W-1:0] out_z
);

    localparam logic signed [ANGLE_W-1:0] ATAN_STEP =
        $signed({{(ANGLE_W-32){1'b0}}, ATAN_Q32[STAGE]});

    logic signed [W-1:0]       x_pre;
    logic signed [W-1:0]       y_pre;
    logic signed [ANGLE_W-1:0] z_pre;
    logic signed [W-1:0]       x_sh;
    logic signed [W-1:0]       y_sh;
    logic signed [W-1:0]       x_next;
    logic signed [W-1:0]       y_next;
    logic signed [ANGLE_W-1:0] z_next;
    logic                      valid_reg;
    logic signed [W-1:0]       x_reg;
    logic signed [W-1:0]       y_reg;
    logic signed [ANGLE_W-1:0] z_reg;
    logic                      load;

    always_comb
    begin
        // Vectoring entry: move a left-half vector to the right half, seed +-pi
        x_pre = in_x;
        y_pre = in_y;
        z_pre = in_z;
        if (MODE == CELL_VECTOR && PRE)
        begin
            z_pre = '0;
            if (in_x < 0)
            begin
                z_pre = (in_y >= 0) ? PI_Q32 : -PI_Q32;
                x_pre = -in_x;
                y_pre = -in_y;
            end
        end

        // One micro-rotation with floor shifts
        x_sh = x_pre >>> STAGE;
        y_sh = y_pre >>> STAGE;
        case (MODE)
            CELL_ROTATE:
            begin
                if (z_pre >= 0)
                begin
                    x_next = x_pre - y_sh;
                    y_next = y_pre + x_sh;
                    z_next = z_pre - ATAN_STEP;
                end
                else
                begin
                    x_next = x_pre + y_sh;
                    y_next = y_pre - x_sh;
                    z_next = z_pre + ATAN_STEP;
                end
            end
            default:
            begin
                if (y_pre >= 0)
                begin
                    x_next = x_pre + y_sh;
                    y_next = y_pre - x_sh;
                    z_next = z_pre + ATAN_STEP;
                end
                else
                begin
                    x_next = x_pre - y_sh;
                    y_next = y_pre + x_sh;
                    z_next = z_pre - ATAN_STEP;
                end
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // Advance when the neighbor takes the word or the cell is empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

/* rtl/core/gtg_back.sv */
module gtg_back
    import gtg_pkg::*;
#(
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ctrl_cfg_t                             cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [DATA_WIDTH+XY_GUARD-1:0] in_x,
    input  logic signed [ANGLE_W-1:0]             in_z,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [14:0]                           linear_speed,
    output logic signed [15:0]                    angular_cmd
);

    localparam int W  = DATA_WIDTH + XY_GUARD;
    localparam int N  = stage_count(CORDIC_STAGES);
    localparam longint unsigned K2  = gain_sq(N);
    localparam longint unsigned INV = (64'd1 << 50) / K2;
    localparam int IW = $clog2(INV + 1);
    localparam int PW = W - 1 + IW;
    localparam int RND_POS = DATA_WIDTH + 9;
    localparam int MW = PW - RND_POS;
    localparam int AW13 = ANGLE_W - 19;
    localparam logic [IW-1:0] INV_C = IW'(INV);
    localparam logic [PW:0]   RND_C = (PW+1)'(1) << RND_POS;
    localparam logic signed [AW13-1:0] PI_HI = AW13'(PI_Q13);
    localparam logic signed [AW13-1:0] PI_LO = -AW13'(PI_Q13);
    localparam logic signed [ANGLE_W-1:0] ANG_RND = ANGLE_W'(1) <<< 18;

    logic                      valid_a_reg;
    logic [PW-1:0]             prod_reg;
    logic signed [ANGLE_W-1:0] ang_reg;
    logic                      valid_b_reg;
    logic [14:0]               speed_reg;
    logic signed [15:0]        angle_reg;
    logic                      ready_a;
    logic                      ready_b;
    logic [PW-1:0]             prod_next;
    logic [PW:0]               sum;
    logic [MW-1:0]             mag;
    logic [14:0]               speed_sat;
    logic signed [ANGLE_W-1:0] ang_t;
    logic signed [AW13-1:0]    ang13;
    logic signed [AW13-1:0]    ang_clamp;
    logic [14:0]               speed_next;
    logic signed [15:0]        angle_next;

    // Stage A: remove the squared gain (x is never negative after vectoring)
    assign prod_next = PW'(in_x[W-2:0]) * PW'(INV_C);

    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
            begin
                valid_a_reg <= in_valid;
            end
            if (ready_b)
            begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && ready_a)
        begin
            prod_reg <= prod_next;
            ang_reg  <= in_z;
        end
    end

    // Stage B: round, saturate, clamp the bearing, apply the stop radius
    always_comb
    begin
        sum       = {1'b0, prod_reg} + RND_C;
        mag       = sum[PW:RND_POS+1];
        speed_sat = (mag > MW'(cfg.max_speed)) ? cfg.max_speed : mag[14:0];

        ang_t = ang_reg + ANG_RND;
        ang13 = AW13'(ang_t >>> 19);
        if (ang13 > PI_HI)
        begin
            ang_clamp = PI_HI;
        end
        else if (ang13 < PI_LO)
        begin
            ang_clamp = PI_LO;
        end
        else
        begin
            ang_clamp = ang13;
        end

        if (speed_sat < cfg.stop_radius)
        begin
            speed_next = '0;
            angle_next = '0;
        end
        else
        begin
            speed_next = speed_sat;
            angle_next = ang_clamp[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_a_reg && ready_b)
        begin
            speed_reg <= speed_next;
            angle_reg <= angle_next;
        end
    end

    assign out_valid    = valid_b_reg;
    assign linear_speed = speed_reg;
    assign angular_cmd  = angle_reg;

endmodule

/* rtl/core/go_to_goal_polar_controller_core.sv */
// Channel  | Direction | Handshake             | Word
// ---------+-----------+-----------------------+----------------------------------------
// pose     | in        | pose_valid/pose_stall | pose_x, pose_y, pose_heading
// cmd      | out       | cmd_valid/cmd_stall   | linear_speed, angular_cmd
// cfg      | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// The pipeline holds one error cell, N rotation cells, N vectoring cells, one gain
// multiply cell and one output cell, N = min(CORDIC_STAGES, 24).
// One pose word is taken per cycle while cmd_stall is low; each cell holds one word and passes it on.
// A stalled cmd word holds in the output cell while upstream bubbles keep filling.
// rst_n clears all valid bits at once and loads the register reset values; cfg_ready
// is always high.
module go_to_goal_polar_controller_core
    import gtg_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pose_valid,
    output logic                  pose_stall,
    input  logic signed [15:0]    pose_x,
    input  logic signed [15:0]    pose_y,
    input  logic signed [15:0]    pose_heading,
    output logic                  cmd_valid,
    input  logic                  cmd_stall,
    output logic [14:0]           linear_speed,
    output logic signed [15:0]    angular_cmd,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int W = DATA_WIDTH + XY_GUARD;
    localparam int N = stage_count(CORDIC_STAGES);

    ctrl_cfg_t cfg_reg;
    ctrl_cfg_t cfg_next;

    logic                      chain_valid [0:2*N];
    logic                      chain_ready [0:2*N];
    logic signed [W-1:0]       chain_x     [0:2*N];
    logic signed [W-1:0]       chain_y     [0:2*N];
    logic signed [ANGLE_W-1:0] chain_z     [0:2*N];
    logic                      front_ready;

    // Register writes; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GOAL_X:      cfg_next.goal_x      = cfg_data;
                REG_GOAL_Y:      cfg_next.goal_y      = cfg_data;
                REG_MAX_SPEED:   cfg_next.max_speed   = cfg_data[14:0];
                REG_STOP_RADIUS: cfg_next.stop_radius = cfg_data[14:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.goal_x      <= '0;
            cfg_reg.goal_y      <= '0;
            cfg_reg.max_speed   <= MAX_SPEED_RST;
            cfg_reg.stop_radius <= STOP_RADIUS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Error and quadrant fold
    gtg_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (pose_valid),
        .in_ready     (front_ready),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_x        (chain_x[0]),
        .out_y        (chain_y[0]),
        .out_z        (chain_z[0])
    );

    assign pose_stall = !front_ready;

    // Rotation cells, then vectoring cells
    for (genvar i = 0; i < 2 * N; i++)
    begin : g_cell
        gtg_cordic_cell #(
            .W     (W),
            .STAGE ((i < N) ? i : i - N),
            .MODE  ((i < N) ? CELL_ROTATE : CELL_VECTOR),
            .PRE   (i == N)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_x      (chain_x[i]),
            .in_y      (chain_y[i]),
            .in_z      (chain_z[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_x     (chain_x[i+1]),
            .out_y     (chain_y[i+1]),
            .out_z     (chain_z[i+1])
        );
    end

    // Gain removal and command shaping; chain_y at the end is the leftover residue
    gtg_back #(
        .DATA_WIDTH    (DATA_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (chain_valid[2*N] && (chain_y[2*N] == chain_y[2*N])),
        .in_ready     (chain_ready[2*N]),
        .in_x         (chain_x[2*N]),
        .in_z         (chain_z[2*N]),
        .out_valid    (cmd_valid),
        .out_ready    (!cmd_stall),
        .linear_speed (linear_speed),
        .angular_cmd  (angular_cmd)
    );

endmodule

/* rtl/core/gtg_checker.sv */
module gtg_checker
    import gtg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               pose_valid,
    input logic               pose_stall,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input logic [14:0]        linear_speed,
    input logic signed [15:0] angular_cmd
);

    localparam logic signed [15:0] PI_HI = 16'(PI_Q13);
    localparam logic signed [15:0] PI_LO = -16'(PI_Q13);

    logic [7:0] inflight_reg;
    logic [7:0] inflight_next;
    logic       pose_take;
    logic       cmd_take;

    assign pose_take = pose_valid && !pose_stall;
    assign cmd_take  = cmd_valid && !cmd_stall;

    // Track words taken in but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (pose_take && !cmd_take)
        begin
            inflight_next = inflight_reg + 8'd1;
        end
        else if (cmd_take && !pose_take)
        begin
            inflight_next = inflight_reg - 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled command word holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(linear_speed)
                                   && $stable(angular_cmd))
        else $error("cmd word changed while stalled");

    // No command without a pose behind it
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> inflight_reg != 8'd0)
        else $error("cmd word delivered with nothing in flight");

    // An empty output cell leaves the whole chain open
    a_open_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_valid |-> !pose_stall)
        else $error("pose stalled while output cell is empty");

    // Bearing stays within +-pi
    a_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (angular_cmd <= PI_HI) && (angular_cmd >= PI_LO))
        else $error("angular_cmd beyond +-pi");

endmodule

bind go_to_goal_polar_controller_core gtg_checker u_gtg_checker (.*);
